// ----- src/tlps_pkg.sv -----
// tlps_pkg: shared types and constants for the two-level scheduler
// no dependencies; imported by every module of the block
package tlps_pkg;

    // one stored job: key = {priority, id}
    typedef struct packed {
        logic [7:0]  prio;
        logic [9:0]  id;
        logic [31:0] arrival;
        logic [15:0] burst;
        logic [15:0] rem;
    } job_t;

    // record passed from cell to cell along the first-level row
    typedef struct packed {
        logic best_valid;
        job_t best;
        job_t last;
    } chain_t;

    // one result transaction
    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  run_id;
        logic        cpu_idle;
        logic        from_second_level;
        logic [31:0] step_start_time;
        logic [7:0]  slice_used;
        logic        job_done;
        logic [9:0]  done_id;
        logic [31:0] completion_time;
        logic [31:0] turnaround;
        logic [31:0] waiting;
    } res_t;

    localparam logic        CMD_ARRIVE = 1'b0;
    localparam logic        CMD_STEP   = 1'b1;

    localparam logic [1:0]  ST_ACCEPTED = 2'd0;
    localparam logic [1:0]  ST_REJECTED = 2'd1;
    localparam logic [1:0]  ST_STEP     = 2'd2;

    localparam logic [1:0]  REG_FIRST_SLICE  = 2'd0;
    localparam logic [1:0]  REG_SECOND_SLICE = 2'd1;

endpackage

// ----- src/tlps_cell.sv -----
// tlps_cell: one slot of the first-level store plus one stage of the min chain
// depends on tlps_pkg
module tlps_cell #(
    parameter int CAPACITY = 16,
    parameter int INDEX    = 0,
    parameter int IW       = 4,
    parameter int CW       = 5
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [CW-1:0]   cnt,
    input  logic            wr_en,
    input  logic [IW-1:0]   wr_idx,
    input  tlps_pkg::job_t  wr_job,
    input  tlps_pkg::chain_t chain_in,
    input  logic [IW-1:0]   idx_in,
    output tlps_pkg::chain_t chain_out,
    output logic [IW-1:0]   idx_out
);
    import tlps_pkg::*;

    job_t         slot_reg;
    chain_t       chain_reg;
    logic [IW-1:0] idx_reg;
    chain_t       chain_next;
    logic [IW-1:0] idx_next;
    logic         mine_valid;
    logic         take_mine;

    always_comb
    begin
        mine_valid = CW'(INDEX) < cnt;
        take_mine  = mine_valid &&
                     (!chain_in.best_valid ||
                      {slot_reg.prio, slot_reg.id} < {chain_in.best.prio, chain_in.best.id});
        chain_next = chain_in;
        idx_next   = idx_in;
        if (take_mine)
        begin
            chain_next.best_valid = 1'b1;
            chain_next.best       = slot_reg;
            idx_next              = IW'(INDEX);
        end
        // entry at the top of the store, used to fill a removed slot
        if (CW'(INDEX + 1) == cnt)
            chain_next.last = slot_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_idx == IW'(INDEX))
            slot_reg <= wr_job;
        idx_reg <= idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chain_reg <= '0;
        else
            chain_reg <= chain_next;
    end

    assign chain_out = chain_reg;
    assign idx_out   = idx_reg;

endmodule

// ----- src/tlps_row.sv -----
// tlps_row: row of first-level cells forming a systolic min-key search
// depends on tlps_pkg and tlps_cell
module tlps_row #(
    parameter int CAPACITY = 16,
    parameter int IW       = 4,
    parameter int CW       = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CW-1:0]    cnt,
    input  logic             wr_en,
    input  logic [IW-1:0]    wr_idx,
    input  tlps_pkg::job_t   wr_job,
    output tlps_pkg::chain_t tail,
    output logic [IW-1:0]    tail_idx
);
    import tlps_pkg::*;

    chain_t        links [CAPACITY+1];
    logic [IW-1:0] idx_links [CAPACITY+1];

    assign links[0]     = '0;
    assign idx_links[0] = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        tlps_cell #(
            .CAPACITY(CAPACITY),
            .INDEX   (i),
            .IW      (IW),
            .CW      (CW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cnt      (cnt),
            .wr_en    (wr_en),
            .wr_idx   (wr_idx),
            .wr_job   (wr_job),
            .chain_in (links[i]),
            .idx_in   (idx_links[i]),
            .chain_out(links[i+1]),
            .idx_out  (idx_links[i+1])
        );
    end

    assign tail     = links[CAPACITY];
    assign tail_idx = idx_links[CAPACITY];

endmodule

// ----- src/two_level_priority_rr_scheduler.sv -----
// two_level_priority_rr_scheduler: top level, sequencer, round-robin fifo
// depends on tlps_pkg and tlps_row
// arrival: result is registered and valid in the cycle after the transaction is accepted
// step: each pass of the min search waits for the row of cells to settle,
//   and a step needs one or two passes
// one item at a time: in_ready is high only when idle and the result register is empty
// reset (async, active low): time 0, cpu idle, both levels empty, slices 1 and 2
module two_level_priority_rr_scheduler #(
    parameter int CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [9:0]  job_id,
    input  logic [7:0]  job_priority,
    input  logic [31:0] job_arrival,
    input  logic [15:0] job_burst,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [9:0]  run_id,
    output logic        cpu_idle,
    output logic        from_second_level,
    output logic [31:0] step_start_time,
    output logic [7:0]  slice_used,
    output logic        job_done,
    output logic [9:0]  done_id,
    output logic [31:0] completion_time,
    output logic [31:0] turnaround,
    output logic [31:0] waiting
);
    import tlps_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN1 = 7'b0000010,  // settle min chain before pick/preempt
        S_PICK  = 7'b0000100,
        S_RUN   = 7'b0001000,
        S_SCAN2 = 7'b0010000,  // settle again after a completion
        S_SEL   = 7'b0100000,
        S_POP   = 7'b1000000   // take fifo head, optionally requeue current job
    } state_t;

    state_t        state_reg, state_next;
    logic [7:0]    slice1_reg, slice2_reg;
    logic [31:0]   now_reg, now_next;
    logic          idle_reg, idle_next;
    logic          rr_reg, rr_next;
    job_t          run_reg, run_next;
    logic [CW-1:0] l1cnt_reg, l1cnt_next;
    logic [CW-1:0] l2cnt_reg, l2cnt_next;
    logic [IW-1:0] head_reg, head_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic          rot_reg, rot_next;
    res_t          res_reg, res_next;
    logic          ov_reg, ov_next;

    // first-level row write port
    logic          l1_we;
    logic [IW-1:0] l1_widx;
    job_t          l1_wjob;
    chain_t        cand;
    logic [IW-1:0] cand_idx;

    // round-robin fifo memory
    job_t          fifo_mem [CAPACITY];
    job_t          fifo_rd_reg;
    logic          fifo_we;
    logic [IW-1:0] tail;
    logic [CW:0]   tail_sum;

    // slice arithmetic for the running job
    logic [7:0]    s_cfg, s_eff, s_run;
    logic [15:0]   rem_new;
    logic [31:0]   now_run, tat;

    tlps_row #(
        .CAPACITY(CAPACITY),
        .IW      (IW),
        .CW      (CW)
    ) u_row (
        .clk     (clk),
        .rst_n   (rst_n),
        .cnt     (l1cnt_reg),
        .wr_en   (l1_we),
        .wr_idx  (l1_widx),
        .wr_job  (l1_wjob),
        .tail    (cand),
        .tail_idx(cand_idx)
    );

    // tail slot = (head + count) mod capacity, sum stays below twice capacity
    assign tail_sum = {1'b0, CW'(head_reg)} + {1'b0, l2cnt_reg};
    assign tail     = (tail_sum >= (CW+1)'(CAPACITY)) ?
                      IW'(tail_sum - (CW+1)'(CAPACITY)) : IW'(tail_sum);

    always_ff @(posedge clk)
    begin
        if (fifo_we)
            fifo_mem[tail] <= run_reg;
        fifo_rd_reg <= fifo_mem[head_reg];
    end

    always_comb
    begin
        s_cfg   = rr_reg ? slice2_reg : slice1_reg;
        s_eff   = (s_cfg == 8'd0) ? 8'd1 : s_cfg;
        s_run   = (run_reg.rem < {8'd0, s_eff}) ? run_reg.rem[7:0] : s_eff;
        rem_new = run_reg.rem - {8'd0, s_run};
        now_run = now_reg + {24'd0, s_run};
        tat     = now_run - run_reg.arrival;
    end

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE) && !ov_reg;

    always_comb
    begin
        state_next = state_reg;
        now_next   = now_reg;
        idle_next  = idle_reg;
        rr_next    = rr_reg;
        run_next   = run_reg;
        l1cnt_next = l1cnt_reg;
        l2cnt_next = l2cnt_reg;
        head_next  = head_reg;
        scan_next  = scan_reg;
        rot_next   = rot_reg;
        res_next   = res_reg;
        ov_next    = ov_reg;
        l1_we      = 1'b0;
        l1_widx    = cand_idx;
        l1_wjob    = cand.last;
        fifo_we    = 1'b0;

        if (ov_reg && out_ready)
            ov_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    if (command == CMD_ARRIVE)
                    begin
                        res_next = '0;
                        ov_next  = 1'b1;
                        if (l1cnt_reg >= CW'(CAPACITY))
                            res_next.status = ST_REJECTED;
                        else
                        begin
                            res_next.status = ST_ACCEPTED;
                            l1_we      = 1'b1;
                            l1_widx    = l1cnt_reg[IW-1:0];
                            l1_wjob    = '{prio: job_priority, id: job_id,
                                           arrival: job_arrival, burst: job_burst,
                                           rem: job_burst};
                            l1cnt_next = l1cnt_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        scan_next  = '0;
                        state_next = S_SCAN1;
                    end
                end
            end
            S_SCAN1, S_SCAN2:
            begin
                scan_next = scan_reg + CW'(1);
                if (scan_reg == CW'(CAPACITY - 1))
                    state_next = (state_reg == S_SCAN1) ? S_PICK : S_SEL;
            end
            S_PICK:
            begin
                if (cand.best_valid &&
                    (idle_reg || (run_reg.prio > cand.best.prio &&
                                  l2cnt_reg < CW'(CAPACITY))))
                begin
                    // preempt: current job to fifo tail
                    if (!idle_reg)
                    begin
                        fifo_we    = 1'b1;
                        l2cnt_next = l2cnt_reg + CW'(1);
                    end
                    run_next   = cand.best;
                    rr_next    = 1'b0;
                    idle_next  = 1'b0;
                    l1_we      = 1'b1;
                    l1cnt_next = l1cnt_reg - CW'(1);
                end
                state_next = S_RUN;
            end
            S_RUN:
            begin
                res_next                 = '0;
                res_next.status          = ST_STEP;
                res_next.step_start_time = now_reg;
                if (idle_reg)
                begin
                    res_next.cpu_idle   = 1'b1;
                    res_next.slice_used = 8'd1;
                    now_next   = now_reg + 32'd1;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    res_next.run_id            = run_reg.id;
                    res_next.from_second_level = rr_reg;
                    res_next.slice_used        = s_run;
                    run_next.rem = rem_new;
                    now_next     = now_run;
                    state_next   = S_IDLE;
                    if (rem_new == 16'd0)
                    begin
                        res_next.job_done        = 1'b1;
                        res_next.done_id         = run_reg.id;
                        res_next.completion_time = now_run;
                        res_next.turnaround      = tat;
                        res_next.waiting         = tat - {16'd0, run_reg.burst};
                        if (l1cnt_reg != '0)
                        begin
                            scan_next  = '0;
                            state_next = S_SCAN2;
                        end
                        else if (l2cnt_reg != '0)
                        begin
                            rot_next   = 1'b0;
                            state_next = S_POP;
                        end
                        else
                        begin
                            idle_next = 1'b1;
                            rr_next   = 1'b0;
                            run_next  = '0;
                            ov_next   = 1'b1;
                        end
                    end
                    else if (rr_reg && l2cnt_reg != '0)
                    begin
                        rot_next   = 1'b1;
                        state_next = S_POP;
                    end
                    else
                        ov_next = 1'b1;
                end
            end
            S_SEL:
            begin
                run_next   = cand.best;
                rr_next    = 1'b0;
                idle_next  = 1'b0;
                l1_we      = 1'b1;
                l1cnt_next = l1cnt_reg - CW'(1);
                ov_next    = 1'b1;
                state_next = S_IDLE;
            end
            S_POP:
            begin
                run_next  = fifo_rd_reg;
                rr_next   = 1'b1;
                idle_next = 1'b0;
                head_next = (head_reg == IW'(CAPACITY - 1)) ? '0 : head_reg + IW'(1);
                // rotation writes the old job at head+count, which equals the new tail
                if (rot_reg)
                    fifo_we = 1'b1;
                else
                    l2cnt_next = l2cnt_reg - CW'(1);
                ov_next    = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
        res_reg <= res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            slice1_reg <= 8'd1;
            slice2_reg <= 8'd2;
            now_reg    <= '0;
            idle_reg   <= 1'b1;
            rr_reg     <= 1'b0;
            run_reg    <= '0;
            l1cnt_reg  <= '0;
            l2cnt_reg  <= '0;
            head_reg   <= '0;
            scan_reg   <= '0;
            rot_reg    <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            now_reg   <= now_next;
            idle_reg  <= idle_next;
            rr_reg    <= rr_next;
            run_reg   <= run_next;
            l1cnt_reg <= l1cnt_next;
            l2cnt_reg <= l2cnt_next;
            head_reg  <= head_next;
            scan_reg  <= scan_next;
            rot_reg   <= rot_next;
            ov_reg    <= ov_next;
            // config transaction; the user must write it only while idle, the block does not enforce this
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_FIRST_SLICE)
                    slice1_reg <= cfg_data;
                else if (cfg_index == REG_SECOND_SLICE)
                    slice2_reg <= cfg_data;
            end
        end
    end

    assign out_valid         = ov_reg;
    assign status            = res_reg.status;
    assign run_id            = res_reg.run_id;
    assign cpu_idle          = res_reg.cpu_idle;
    assign from_second_level = res_reg.from_second_level;
    assign step_start_time   = res_reg.step_start_time;
    assign slice_used        = res_reg.slice_used;
    assign job_done          = res_reg.job_done;
    assign done_id           = res_reg.done_id;
    assign completion_time   = res_reg.completion_time;
    assign turnaround        = res_reg.turnaround;
    assign waiting           = res_reg.waiting;

endmodule

// ----- src/tlps_checker.sv -----
// tlps_checker: port-level assertions for the two-level scheduler
// depends on tlps_pkg; bound to two_level_priority_rr_scheduler
module tlps_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [9:0]  run_id,
    input logic        cpu_idle,
    input logic [7:0]  slice_used,
    input logic        job_done,
    input logic [9:0]  done_id,
    input logic [31:0] turnaround
);
    import tlps_pkg::*;

    // a stalled result transaction holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(run_id) && $stable(status))
        else $error("result changed while stalled");

    // arrival results carry nothing but status
    a_arrive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_ACCEPTED || status == ST_REJECTED) |->
        run_id == '0 && !cpu_idle && slice_used == '0 && !job_done)
        else $error("arrival result with step fields");

    // idle step consumes one unit and runs nobody
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cpu_idle |-> run_id == '0 && slice_used == 8'd1 && !job_done)
        else $error("bad idle step");

    // completion reports the job that ran, otherwise zeros
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_STEP |->
        (job_done && done_id == run_id) || (!job_done && done_id == '0 && turnaround == '0))
        else $error("completion fields inconsistent");

endmodule

bind two_level_priority_rr_scheduler tlps_checker u_tlps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .run_id    (run_id),
    .cpu_idle  (cpu_idle),
    .slice_used(slice_used),
    .job_done  (job_done),
    .done_id   (done_id),
    .turnaround(turnaround)
);
